// File: rtl/ecss_pkg.sv
// ----------------------------------------------------------------------------
// ecss_pkg: shared types and constants
// Widths, codes and the segment font for the encoder count display block.
// ----------------------------------------------------------------------------
package ecss_pkg;

  localparam int COUNT_W = 14;
  localparam int SEG_W   = 7;
  localparam int EN_W    = 4;
  localparam int BCD_N   = 4;
  localparam int DIGITS  = 4;
  localparam int PHASE_W = $clog2(DIGITS);
  localparam int CONV_W  = $clog2(COUNT_W + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX_RESET = 14'd4095;
  localparam logic [COUNT_W-1:0] SHOW_LIMIT      = 14'd9999;
  localparam logic [SEG_W-1:0]   BLANK_SEGS      = 7'h7F;
  localparam logic [EN_W-1:0]    ENABLES_OFF     = 4'hF;

  localparam logic OP_ENCODER = 1'b0;
  localparam logic OP_SCAN    = 1'b1;

  typedef logic [BCD_N-1:0][3:0] bcd_t;

  localparam bcd_t COUNT_MAX_RESET_BCD = 16'h4095;

  typedef struct packed {
    logic [COUNT_W-1:0] top;
    bcd_t               top_bcd;
  } limit_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [EN_W-1:0]    digit_enable_n;
    logic [SEG_W-1:0]   segments_n;
  } result_t;

  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
    logic [SEG_W-1:0] s;
    case (digit)
      4'd0:    s = 7'h40;
      4'd1:    s = 7'h79;
      4'd2:    s = 7'h24;
      4'd3:    s = 7'h30;
      4'd4:    s = 7'h19;
      4'd5:    s = 7'h12;
      4'd6:    s = 7'h02;
      4'd7:    s = 7'h78;
      4'd8:    s = 7'h00;
      4'd9:    s = 7'h10;
      default: s = BLANK_SEGS;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/ecss_cfg.sv
// ----------------------------------------------------------------------------
// ecss_cfg: count limit register
// Holds count_max, saturates it at the display limit and converts the limit
// to BCD by shift-and-add-3, one bit a cycle, after each write.
// ----------------------------------------------------------------------------
module ecss_cfg import ecss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [COUNT_W-1:0] cfg_data_i,
  output logic               busy_o,
  output limit_t             limit_o
);

  logic [COUNT_W-1:0] top_q, top_d;
  logic [COUNT_W-1:0] bin_q, bin_d;
  bcd_t               bcd_q, bcd_d;
  logic [CONV_W-1:0]  cnt_q, cnt_d;
  logic               busy;
  logic               wr;
  logic [COUNT_W-1:0] sat;
  bcd_t               adj;

  assign busy        = (cnt_q != '0);
  assign cfg_ready_o = !busy;
  assign wr          = cfg_valid_i && !busy;
  assign sat         = (cfg_data_i > SHOW_LIMIT) ? SHOW_LIMIT : cfg_data_i;

  always_comb begin
    for (int i = 0; i < BCD_N; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  always_comb begin
    top_d = top_q;
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (wr) begin
      top_d = sat;
      bin_d = sat;
      bcd_d = '0;
      cnt_d = CONV_W'(COUNT_W);
    end else if (busy) begin
      bcd_d = bcd_t'({adj, bin_q[COUNT_W-1]});
      bin_d = {bin_q[COUNT_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= COUNT_MAX_RESET;
      bin_q <= '0;
      bcd_q <= COUNT_MAX_RESET_BCD;
      cnt_q <= '0;
    end else begin
      top_q <= top_d;
      bin_q <= bin_d;
      bcd_q <= bcd_d;
      cnt_q <= cnt_d;
    end
  end

  assign busy_o          = busy;
  assign limit_o.top     = top_q;
  assign limit_o.top_bcd = bcd_q;

endmodule

// File: rtl/ecss_count_step.sv
// ----------------------------------------------------------------------------
// ecss_count_step: encoder count update
// Next binary count and its BCD copy for one encoder edge, with wrap.
// ----------------------------------------------------------------------------
module ecss_count_step import ecss_pkg::*; (
  input  logic [COUNT_W-1:0] count_i,
  input  bcd_t               bcd_i,
  input  logic               enc_data_i,
  input  logic               enc_clock_i,
  input  limit_t             limit_i,
  output logic [COUNT_W-1:0] count_o,
  output bcd_t               bcd_o
);

  bcd_t inc, dec;
  logic carry, borrow;

  always_comb begin
    carry  = 1'b1;
    borrow = 1'b1;
    for (int i = 0; i < BCD_N; i++) begin
      inc[i] = bcd_i[i];
      dec[i] = bcd_i[i];
      if (carry) begin
        if (bcd_i[i] == 4'd9) begin
          inc[i] = 4'd0;
        end else begin
          inc[i] = bcd_i[i] + 4'd1;
          carry  = 1'b0;
        end
      end
      if (borrow) begin
        if (bcd_i[i] == 4'd0) begin
          dec[i] = 4'd9;
        end else begin
          dec[i] = bcd_i[i] - 4'd1;
          borrow = 1'b0;
        end
      end
    end
  end

  always_comb begin
    count_o = count_i;
    bcd_o   = bcd_i;
    if (enc_data_i) begin
      if (enc_clock_i) begin
        if (count_i >= limit_i.top) begin
          count_o = '0;
          bcd_o   = '0;
        end else begin
          count_o = count_i + 1'b1;
          bcd_o   = inc;
        end
      end else begin
        if (count_i == '0 || count_i > limit_i.top) begin
          count_o = limit_i.top;
          bcd_o   = limit_i.top_bcd;
        end else begin
          count_o = count_i - 1'b1;
          bcd_o   = dec;
        end
      end
    end
  end

endmodule

// File: rtl/ecss_scan_step.sv
// ----------------------------------------------------------------------------
// ecss_scan_step: display scan step
// Digit enable, segment pattern with leading-zero blanking, next phase.
// ----------------------------------------------------------------------------
module ecss_scan_step import ecss_pkg::*; (
  input  logic [PHASE_W-1:0] phase_i,
  input  bcd_t               bcd_i,
  output logic [PHASE_W-1:0] phase_o,
  output logic [SEG_W-1:0]   segments_n_o,
  output logic [EN_W-1:0]    digit_enable_n_o
);

  logic show;

  always_comb begin
    show = (phase_i == '0);
    for (int i = 0; i < BCD_N; i++) begin
      if (i >= int'(phase_i) && bcd_i[i] != 4'd0) begin
        show = 1'b1;
      end
    end
  end

  always_comb begin
    segments_n_o     = BLANK_SEGS;
    digit_enable_n_o = ENABLES_OFF;
    if (int'(phase_i) < EN_W) begin
      digit_enable_n_o = ~(EN_W'(1) << phase_i[1:0]);
      if (show) begin
        segments_n_o = seg_code(bcd_i[phase_i[1:0]]);
      end
    end
    if (int'(phase_i) >= DIGITS - 1) begin
      phase_o = '0;
    end else begin
      phase_o = phase_i + 1'b1;
    end
  end

endmodule

// File: rtl/encoder_count_seven_segment_scan_core.sv
// ----------------------------------------------------------------------------
// encoder_count_seven_segment_scan_core: encoder count with display scan
// Each accepted input word yields one result word, held in a result queue.
// Throughput: one word per cycle; a two-entry result queue absorbs stalls.
// After a count_max write the limit is converted to BCD; while that runs,
// no input word or further write is taken.
// Reset: count 0, units digit next, segments and enables all off, limit 4095.
// ----------------------------------------------------------------------------
module encoder_count_seven_segment_scan_core import ecss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [COUNT_W-1:0] cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // enc_data, enc_clock, zero fill
  input  logic               s_axis_tuser,  // op
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata   // segments_n, digit_enable_n, count, fill
);

  logic               busy;
  limit_t             limit;
  logic [COUNT_W-1:0] count_q, count_d, count_nx;
  bcd_t               bcd_q, bcd_d, bcd_nx;
  logic [PHASE_W-1:0] phase_q, phase_d, phase_nx;
  logic [SEG_W-1:0]   segs_q, segs_d, segs_nx;
  logic [EN_W-1:0]    ens_q, ens_d, ens_nx;
  result_t            fifo_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         fill_q;
  logic               push, pop;
  result_t            res;

  ecss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .limit_o     (limit)
  );

  ecss_count_step u_count (
    .count_i     (count_q),
    .bcd_i       (bcd_q),
    .enc_data_i  (s_axis_tdata[0]),
    .enc_clock_i (s_axis_tdata[1]),
    .limit_i     (limit),
    .count_o     (count_nx),
    .bcd_o       (bcd_nx)
  );

  ecss_scan_step u_scan (
    .phase_i          (phase_q),
    .bcd_i            (bcd_q),
    .phase_o          (phase_nx),
    .segments_n_o     (segs_nx),
    .digit_enable_n_o (ens_nx)
  );

  assign s_axis_tready = !busy && (fill_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (fill_q != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_comb begin
    count_d = count_q;
    bcd_d   = bcd_q;
    phase_d = phase_q;
    segs_d  = segs_q;
    ens_d   = ens_q;
    if (push) begin
      if (s_axis_tuser == OP_SCAN) begin
        phase_d = phase_nx;
        segs_d  = segs_nx;
        ens_d   = ens_nx;
      end else begin
        count_d = count_nx;
        bcd_d   = bcd_nx;
      end
    end
  end

  assign res.count          = count_d;
  assign res.digit_enable_n = ens_d;
  assign res.segments_n     = segs_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      bcd_q    <= '0;
      phase_q  <= '0;
      segs_q   <= BLANK_SEGS;
      ens_q    <= ENABLES_OFF;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      count_q <= count_d;
      bcd_q   <= bcd_d;
      phase_q <= phase_d;
      segs_q  <= segs_d;
      ens_q   <= ens_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  assign m_axis_tdata = {7'd0, fifo_q[rd_ptr_q]};

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: encoder count and seven-segment scan testbench
// Drives encoder events and scan ticks over the input stream, moves count_max
// between phases and checks every result word against directed rows or a
// cycle-free model of the count and display state. Random input bursts, a
// stall pattern on the output side, one long output hold-off and idle drains.
// ----------------------------------------------------------------------------
module tb_top;
  import ecss_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned N_PHASES    = 10;
  localparam int unsigned PHASE_ITEMS = 63;

  localparam logic [SEG_W-1:0] SEG_FONT [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
  };
  localparam int unsigned PLACE_W [4] = '{1, 10, 100, 1000};

  typedef enum logic {ROW_WORD, ROW_LIMIT} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [COUNT_W-1:0] limit;
    logic               op;
    logic               enc_data;
    logic               enc_clock;
    bit                 typed;
    logic [SEG_W-1:0]   segs;
    logic [EN_W-1:0]    ens;
    logic [COUNT_W-1:0] cnt;
  } dir_row_t;

  localparam int N_ROWS = 30;

  dir_row_t dir_rows [N_ROWS] = '{
    '{ROW_WORD,  0,     OP_SCAN,    0, 0, 1, 7'h40, 4'hE, 0},
    '{ROW_WORD,  0,     OP_SCAN,    1, 1, 1, 7'h7F, 4'hD, 0},
    '{ROW_WORD,  0,     OP_SCAN,    0, 1, 1, 7'h7F, 4'hB, 0},
    '{ROW_WORD,  0,     OP_SCAN,    1, 0, 1, 7'h7F, 4'h7, 0},
    '{ROW_WORD,  0,     OP_ENCODER, 0, 1, 1, 7'h7F, 4'h7, 0},
    '{ROW_WORD,  0,     OP_ENCODER, 1, 0, 1, 7'h7F, 4'h7, 4095},
    '{ROW_WORD,  0,     OP_SCAN,    0, 0, 1, 7'h12, 4'hE, 4095},
    '{ROW_WORD,  0,     OP_SCAN,    0, 0, 1, 7'h10, 4'hD, 4095},
    '{ROW_WORD,  0,     OP_SCAN,    0, 0, 1, 7'h40, 4'hB, 4095},
    '{ROW_WORD,  0,     OP_SCAN,    0, 0, 1, 7'h19, 4'h7, 4095},
    '{ROW_WORD,  0,     OP_ENCODER, 1, 1, 1, 7'h19, 4'h7, 0},
    '{ROW_WORD,  0,     OP_ENCODER, 1, 1, 1, 7'h19, 4'h7, 1},
    '{ROW_WORD,  0,     OP_ENCODER, 1, 0, 1, 7'h19, 4'h7, 0},
    '{ROW_LIMIT, 0,     0,          0, 0, 0, 0,     0,    0},
    '{ROW_WORD,  0,     OP_ENCODER, 1, 1, 1, 7'h19, 4'h7, 0},
    '{ROW_WORD,  0,     OP_ENCODER, 1, 0, 1, 7'h19, 4'h7, 0},
    '{ROW_LIMIT, 16383, 0,          0, 0, 0, 0,     0,    0},
    '{ROW_WORD,  0,     OP_ENCODER, 1, 0, 1, 7'h19, 4'h7, 9999},
    '{ROW_WORD,  0,     OP_SCAN,    0, 0, 1, 7'h10, 4'hE, 9999},
    '{ROW_WORD,  0,     OP_SCAN,    0, 0, 1, 7'h10, 4'hD, 9999},
    '{ROW_WORD,  0,     OP_SCAN,    0, 0, 1, 7'h10, 4'hB, 9999},
    '{ROW_WORD,  0,     OP_SCAN,    0, 0, 1, 7'h10, 4'h7, 9999},
    '{ROW_WORD,  0,     OP_ENCODER, 1, 1, 1, 7'h10, 4'h7, 0},
    '{ROW_WORD,  0,     OP_ENCODER, 1, 0, 1, 7'h10, 4'h7, 9999},
    '{ROW_LIMIT, 1,     0,          0, 0, 0, 0,     0,    0},
    '{ROW_WORD,  0,     OP_ENCODER, 1, 1, 1, 7'h10, 4'h7, 0},
    '{ROW_LIMIT, 9999,  0,          0, 0, 0, 0,     0,    0},
    '{ROW_WORD,  0,     OP_ENCODER, 1, 0, 1, 7'h10, 4'h7, 9999},
    '{ROW_LIMIT, 5,     0,          0, 0, 0, 0,     0,    0},
    '{ROW_WORD,  0,     OP_ENCODER, 1, 0, 1, 7'h10, 4'h7, 5}
  };

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [COUNT_W-1:0] cfg_data_i    = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = '0;  // enc_data, enc_clock, zero fill
  logic               s_axis_tuser  = 1'b0;  // op
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;  // segments_n, digit_enable_n, count, fill

  encoder_count_seven_segment_scan_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // display model state
  int unsigned      count_limit = COUNT_MAX_RESET;
  int unsigned      disp_count  = 0;
  int unsigned      disp_phase  = 0;
  logic [SEG_W-1:0] disp_segs   = BLANK_SEGS;
  logic [EN_W-1:0]  disp_ens    = ENABLES_OFF;

  result_t     pending_words [$];
  int unsigned err_count   = 0;
  int unsigned quiet_count = 0;
  int unsigned hold_req    = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
    err_count++;
  endtask

  task automatic advance_display(input logic op, input logic enc_data,
                                 input logic enc_clock, output result_t r);
    int unsigned top;
    int unsigned w;
    top = (count_limit > SHOW_LIMIT) ? SHOW_LIMIT : count_limit;
    if (op == OP_ENCODER) begin
      if (enc_data) begin
        if (enc_clock) begin
          disp_count = (disp_count >= top) ? 0 : disp_count + 1;
        end else begin
          disp_count = (disp_count == 0 || disp_count > top) ? top : disp_count - 1;
        end
      end
    end else begin
      w = PLACE_W[disp_phase];
      disp_ens  = ENABLES_OFF & ~(EN_W'(1) << disp_phase);
      disp_segs = (disp_phase == 0 || disp_count >= w) ? SEG_FONT[(disp_count / w) % 10]
                                                       : BLANK_SEGS;
      disp_phase = (disp_phase == DIGITS - 1) ? 0 : disp_phase + 1;
    end
    r.count          = disp_count[COUNT_W-1:0];
    r.digit_enable_n = disp_ens;
    r.segments_n     = disp_segs;
  endtask

  task automatic put_word(input logic op, input logic enc_data, input logic enc_clock,
                          input bit typed, input result_t typed_word);
    result_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, enc_clock, enc_data};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    advance_display(op, enc_data, enc_clock, r);
    pending_words.push_back(typed ? typed_word : r);
  endtask

  task automatic pause_input(input int unsigned n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_words();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [COUNT_W-1:0] v);
    drain_words();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    count_limit = v;
  endtask

  // output side stall pattern, with one long hold-off on request
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned run_left  = 0;
  bit          run_ready = 1'b1;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_ready = ($urandom_range(0, 2) != 0);
        run_left  = run_ready ? $urandom_range(1, 24) : $urandom_range(1, 5);
      end
      run_left--;
      m_axis_tready <= run_ready;
    end
  end

  // result checker and quiet-cycle counter
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o)) begin
        quiet_count <= 0;
      end else begin
        quiet_count <= quiet_count + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_words.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata, 0);
        end else begin
          want = pending_words.pop_front();
          if (m_axis_tdata[6:0] !== want.segments_n)
            report_mismatch("segments_n", m_axis_tdata[6:0], want.segments_n);
          if (m_axis_tdata[10:7] !== want.digit_enable_n)
            report_mismatch("digit_enable_n", m_axis_tdata[10:7], want.digit_enable_n);
          if (m_axis_tdata[24:11] !== want.count)
            report_mismatch("count", m_axis_tdata[24:11], want.count);
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_count < QUIET_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic [COUNT_W-1:0] phase_limit [N_PHASES];
    result_t     typed_word;
    int unsigned sent;
    int unsigned burst;
    int unsigned bias;
    logic        op;
    logic        enc_data;
    logic        enc_clock;

    phase_limit = '{9999, 37, 1000, 16383, 0, 1, 14'd0, 2, 12, COUNT_MAX_RESET};
    phase_limit[6] = $urandom_range(1, 9999);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LIMIT) begin
        write_limit(dir_rows[i].limit);
      end else begin
        typed_word.count          = dir_rows[i].cnt;
        typed_word.digit_enable_n = dir_rows[i].ens;
        typed_word.segments_n     = dir_rows[i].segs;
        put_word(dir_rows[i].op, dir_rows[i].enc_data, dir_rows[i].enc_clock,
                 dir_rows[i].typed, typed_word);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_limit(phase_limit[ph]);
      bias = $urandom_range(0, 2);
      sent = 0;
      if (ph == 1) begin
        // output held off while input keeps coming: fills the result queue
        hold_req++;
        for (int k = 0; k < 24; k++) begin
          put_word($urandom_range(0, 1), 1'b1, $urandom_range(0, 1), 1'b0, '0);
        end
        sent = 24;
      end
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 16);
        for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          op       = $urandom_range(0, 1);
          enc_data = ($urandom_range(0, 9) != 0);
          case (bias)
            0:       enc_clock = $urandom_range(0, 1);
            1:       enc_clock = ($urandom_range(0, 4) != 0);
            default: enc_clock = ($urandom_range(0, 4) == 0);
          endcase
          put_word(op, enc_data, enc_clock, 1'b0, '0);
          sent++;
        end
        if (ph == 3 && sent >= PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 17) begin
          drain_words();
        end else if (ph != 2 && $urandom_range(0, 9) < 7) begin
          pause_input($urandom_range(1, 6));
        end
      end
    end

    drain_words();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
